@@ hdl/hidsk_pkg.sv @@
// Shared types and constants of the HID six-key report tracker.
`default_nettype none

package hidsk_pkg;

    // Event modes.
    localparam logic MODE_KEY    = 1'b0;
    localparam logic MODE_TOGGLE = 1'b1;

    // Key kinds; codes above KT_MEDIA are ignored.
    localparam logic [2:0] KT_NORMAL   = 3'd0;
    localparam logic [2:0] KT_MODIFIER = 3'd1;
    localparam logic [2:0] KT_SYSTEM   = 3'd2;
    localparam logic [2:0] KT_MEDIA    = 3'd3;

    // GUI modifier bits and their exact event codes.
    localparam logic [7:0] GUI_MASK       = 8'h88;
    localparam logic [9:0] GUI_LEFT_CODE  = 10'h008;
    localparam logic [9:0] GUI_RIGHT_CODE = 10'h080;

    // Report layout.
    localparam int OUT_SLOTS = 6;
    localparam int KEY_W     = 8;
    localparam int MOD_W     = 8;
    localparam int CODE_W    = 10;
    localparam int TYPE_W    = 3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // latch the input beat, rewind the slot cursor
        logic simple;      // execute a non-slot event in one step
        logic set_send;    // load the send flag with send_val
        logic send_val;
        logic write_code;  // store the key code in the slot under the cursor
        logic idx_inc;     // advance the slot cursor
        logic shift;       // pull the next slot down and advance the cursor
        logic clear_last;  // empty the last slot
        logic out_load;    // copy the report into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic normal_ev;   // latched event is a normal key event
        logic hit;         // slot under the cursor holds the key code
        logic empty;       // slot under the cursor is empty
        logic last;        // cursor sits on the last slot
        logic pressed;     // latched event is a press
        logic out_full;    // output register holds an untaken beat
    } t_status;

endpackage

`default_nettype wire

@@ hdl/hidsk_ctrl.sv @@
// Controller state machine of the HID six-key report tracker.
`default_nettype none

module hidsk_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire                i_out_ready,
    input  hidsk_pkg::t_status i_status,
    output hidsk_pkg::t_cmd    o_cmd
);
    import hidsk_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_status.normal_ev) begin
                    n_state = ST_SCAN;
                end else begin
                    o_cmd.simple = 1'b1;
                    n_state      = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (i_status.hit) begin
                    // A held key: a press changes nothing, a release compacts.
                    o_cmd.set_send = 1'b1;
                    o_cmd.send_val = !i_status.pressed;
                    n_state        = i_status.pressed ? ST_DONE : ST_SHIFT;
                end else if (i_status.empty) begin
                    o_cmd.set_send   = 1'b1;
                    o_cmd.send_val   = i_status.pressed;
                    o_cmd.write_code = i_status.pressed;
                    n_state          = ST_DONE;
                end else if (i_status.last) begin
                    // All slots full and no match.
                    o_cmd.set_send = 1'b1;
                    o_cmd.send_val = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_SHIFT: begin
                if (i_status.last) begin
                    o_cmd.clear_last = 1'b1;
                    n_state          = ST_DONE;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            ST_DONE: begin
                if (!i_status.out_full || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The output register is never overwritten while it still holds a beat.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!i_status.out_full || i_out_ready))
        else $error("report loaded over an untaken beat");

    // A release that hits a slot always goes on to compaction.
    a_release_shifts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_status.hit && !i_status.pressed) |=> (r_state == ST_SHIFT))
        else $error("release hit did not enter compaction");

endmodule

`default_nettype wire

@@ hdl/hidsk_dp.sv @@
// Datapath of the HID six-key report tracker: slots, modifiers, media and output register.
`default_nettype none

module hidsk_dp #(
    parameter int SLOT_COUNT = 6
) (
    input  wire                                                   i_clk,
    input  wire                                                   i_rst_n,
    input  hidsk_pkg::t_cmd                                       i_cmd,
    output hidsk_pkg::t_status                                    o_status,
    input  wire                                                   i_in_mode,
    input  wire  [hidsk_pkg::TYPE_W-1:0]                          i_in_type,
    input  wire  [hidsk_pkg::CODE_W-1:0]                          i_in_code,
    input  wire                                                   i_in_pressed,
    input  wire                                                   i_out_ready,
    output logic                                                  o_out_valid,
    output logic [hidsk_pkg::MOD_W-1:0]                           o_out_mod,
    output logic [hidsk_pkg::OUT_SLOTS-1:0][hidsk_pkg::KEY_W-1:0] o_out_slots,
    output logic [hidsk_pkg::CODE_W-1:0]                          o_out_media,
    output logic                                                  o_out_send
);
    import hidsk_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    // Latched event.
    logic              r_mode;
    logic [TYPE_W-1:0] r_type;
    logic [CODE_W-1:0] r_code;
    logic              r_pressed;

    // Report state.
    logic [KEY_W-1:0]  r_slot [SLOT_COUNT];
    logic [MOD_W-1:0]  r_mod;
    logic [CODE_W-1:0] r_media;
    logic              r_gui;
    logic              r_send;
    logic [IDX_W-1:0]  r_idx;
    logic              r_out_valid;

    logic [MOD_W-1:0]  n_mod;
    logic [CODE_W-1:0] n_media;
    logic              n_gui;
    logic              n_send;

    logic [SLOT_COUNT-1:0] hit_vec;
    logic [SLOT_COUNT-1:0] empty_vec;
    logic                  gui_code;
    logic                  mod_hit;

    always_comb begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            hit_vec[s]   = (r_slot[s] == r_code[KEY_W-1:0]);
            empty_vec[s] = (r_slot[s] == '0);
        end
    end

    assign o_status.normal_ev = (r_mode == MODE_KEY) && (r_type == KT_NORMAL);
    assign o_status.hit       = hit_vec[r_idx];
    assign o_status.empty     = empty_vec[r_idx];
    assign o_status.last      = (r_idx == LAST_IDX);
    assign o_status.pressed   = r_pressed;
    assign o_status.out_full  = r_out_valid;

    // Every event other than a normal key resolves in a single step.
    assign gui_code = (r_code == GUI_LEFT_CODE) || (r_code == GUI_RIGHT_CODE);
    assign mod_hit  = ((r_mod & r_code[MOD_W-1:0]) != '0);

    always_comb begin
        n_mod   = r_mod;
        n_media = r_media;
        n_gui   = r_gui;
        n_send  = 1'b0;
        if (r_mode == MODE_TOGGLE) begin
            if (r_gui) begin
                n_mod  = r_mod & ~GUI_MASK;
                n_send = ((r_mod & GUI_MASK) != '0);
            end
            n_gui = !r_gui;
        end else if (r_type == KT_MODIFIER && gui_code && !r_gui) begin
            n_send = 1'b0;
        end else begin
            case (r_type)
                KT_MODIFIER: begin
                    if (r_pressed) begin
                        if (!mod_hit) begin
                            n_mod  = r_mod | r_code[MOD_W-1:0];
                            n_send = 1'b1;
                        end
                    end else if (mod_hit) begin
                        n_mod  = r_mod & ~r_code[MOD_W-1:0];
                        n_send = 1'b1;
                    end
                end
                KT_SYSTEM: begin
                    n_send = 1'b1;
                end
                KT_MEDIA: begin
                    n_media = r_pressed ? r_code : '0;
                    n_send  = 1'b1;
                end
                default: begin
                    n_send = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_in_mode;
            r_type    <= i_in_type;
            r_code    <= i_in_code;
            r_pressed <= i_in_pressed;
        end
        if (i_cmd.simple) begin
            r_send <= n_send;
        end else if (i_cmd.set_send) begin
            r_send <= i_cmd.send_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod       <= '0;
            r_media     <= '0;
            r_gui       <= 1'b1;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.simple) begin
                r_mod   <= n_mod;
                r_media <= n_media;
                r_gui   <= n_gui;
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc || i_cmd.shift) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // One cell per slot; each cell sees only its upper neighbor.
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_slot[g] <= '0;
            end else if (i_cmd.write_code && r_idx == IDX_W'(g)) begin
                r_slot[g] <= r_code[KEY_W-1:0];
            end else if (i_cmd.clear_last && g == SLOT_COUNT - 1) begin
                r_slot[g] <= '0;
            end else if (i_cmd.shift && r_idx == IDX_W'(g) && !empty_vec[g]) begin
                if (g < SLOT_COUNT - 1) begin
                    r_slot[g] <= r_slot[(g < SLOT_COUNT - 1) ? g + 1 : g];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_mod   <= r_mod;
            o_out_media <= r_media;
            o_out_send  <= r_send;
            for (int s = 0; s < OUT_SLOTS; s++) begin
                o_out_slots[s] <= (s < SLOT_COUNT) ? r_slot[(s < SLOT_COUNT) ? s : 0] : '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // Compaction never runs past the last slot.
    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift |-> (r_idx != LAST_IDX))
        else $error("slot shift issued at the last slot");

    // A new key only lands in an empty slot that did not match it.
    a_write_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write_code |-> (empty_vec[r_idx] && !hit_vec[r_idx]))
        else $error("key code written over a held slot");

    // A loaded report is offered in the next cycle.
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded report not offered");

endmodule

`default_nettype wire

@@ hdl/hid_six_key_report_tracker_core.sv @@
// Top level of the HID six-key report tracker: controller, datapath and stream ports.
//
//  Channel  Dir  Beat contents (lowest bits first)
//  s_axis   in   tdata: usage code, pressed; tuser: mode, key kind
//  m_axis   out  tdata: modifier_bits, slot_one..slot_six, media_code; tuser: send_report
//
// Sequence: an event is taken in the idle state, decoded in the next cycle and written
// to the output register in the done state. Toggle, modifier, system, media and unknown
// events pass only through the idle, decode and done states. A normal key walks the
// slots one per cycle until it meets its code, an empty slot or the end; a release that
// finds its key then compacts from there to the last slot one per cycle. The slot cursor
// steers both the scan and the compaction.
// Reset: synchronous and active low; slots, modifiers and media clear, GUI keys are enabled.
// Stalls: a new event is taken while the previous report waits in the output register;
// an event only waits in its last cycle if that register is still occupied.
`default_nettype none

module hid_six_key_report_tracker_core #(
    parameter int SLOT_COUNT = 6
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // usage [9:0], pressed [10], zero [15:11]
    input  wire  [3:0]  s_axis_tuser,   // mode [0], kind [3:1]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [71:0] m_axis_tdata,   // modifier_bits [7:0], slot_one..slot_six [55:8],
                                        // media_usage [65:56], zero [71:66]
    output logic [0:0]  m_axis_tuser    // send_report [0]
);
    import hidsk_pkg::*;

    t_cmd    cmd;
    t_status status;

    logic [MOD_W-1:0]                out_mod;
    logic [OUT_SLOTS-1:0][KEY_W-1:0] out_slots;
    logic [CODE_W-1:0]               out_media;
    logic                            out_send;

    // The controller sequences each event; the datapath holds the report.
    hidsk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    hidsk_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_in_mode    (s_axis_tuser[0]),
        .i_in_type    (s_axis_tuser[3:1]),
        .i_in_code    (s_axis_tdata[9:0]),
        .i_in_pressed (s_axis_tdata[10]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_mod    (out_mod),
        .o_out_slots  (out_slots),
        .o_out_media  (out_media),
        .o_out_send   (out_send)
    );

    // The packed slot array already lies with slot one in the lowest byte.
    assign m_axis_tdata = {6'b0, out_media, out_slots, out_mod};
    assign m_axis_tuser = out_send;

endmodule

`default_nettype wire
